FILE: rtl/core/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg
// Types and constants shared by the button press duration classifier.
// ----------------------------------------------------------------------------
package bpdc_pkg;

  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [HOLD_W-1:0]  hold_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_SELECT_HOLD  = 2'd1,
    REG_ESCAPE_HOLD  = 2'd2,
    REG_ACTIVE_LEVEL = 2'd3
  } reg_idx_t;

  localparam hold_t DEBOUNCE_RST     = hold_t'(75);
  localparam hold_t SELECT_HOLD_RST  = hold_t'(550);
  localparam hold_t ESCAPE_HOLD_RST  = hold_t'(1200);
  localparam logic  ACTIVE_LEVEL_RST = 1'b0;

  typedef struct packed {
    logic next_press;
    logic select_press;
    logic escape_press;
    logic any_key;
    logic long_press;
  } flags_t;

endpackage

FILE: rtl/core/bpdc_if.sv
// ----------------------------------------------------------------------------
// bpdc channel interfaces
// Valid/ready channels for polls in and classified results out.
// ----------------------------------------------------------------------------
interface bpdc_poll_if;
  logic             valid;
  logic             ready;
  bpdc_pkg::stamp_t now_ms;
  logic             button_level;

  modport source (output valid, output now_ms, output button_level, input ready);
  modport sink   (input valid, input now_ms, input button_level, output ready);
endinterface

interface bpdc_result_if;
  logic valid;
  logic ready;
  logic poll_taken;
  logic next_press;
  logic select_press;
  logic escape_press;
  logic any_key;
  logic long_press;

  modport source (output valid, output poll_taken, output next_press,
                  output select_press, output escape_press, output any_key,
                  output long_press, input ready);
  modport sink   (input valid, input poll_taken, input next_press,
                  input select_press, input escape_press, input any_key,
                  input long_press, output ready);
endinterface

FILE: rtl/core/button_press_duration_classifier.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier
// Debounces timestamped button polls and classifies presses by hold time.
// ----------------------------------------------------------------------------
// Each accepted poll beat gives one result beat out in the next cycle; a poll is taken
// every cycle as long as the result register is empty or being drained. The
// whole classification is a pair of modular subtractions and compares against
// the configured thresholds, done between the state registers and the result
// register. Timestamps are used modulo 2^TIME_WIDTH. Configuration goes through
// the APB port (debounce, select hold, escape hold, active level at 0x0, 0x4,
// 0x8, 0xC) and should only be written while the block is idle.
module button_press_duration_classifier #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  bpdc_poll_if.sink                   poll,
  bpdc_result_if.source               result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpdc_pkg::APB_AW-1:0] paddr,
  input  logic [bpdc_pkg::APB_DW-1:0] pwdata,
  output logic [bpdc_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  typedef logic [TIME_WIDTH-1:0] tval_t;

  bpdc_pkg::hold_t   debounce_ms;
  bpdc_pkg::hold_t   select_hold_ms;
  bpdc_pkg::hold_t   escape_hold_ms;
  logic              active_level;

  tval_t             last_activity_time;
  tval_t             press_start_time;
  logic              was_pressed;
  bpdc_pkg::flags_t  flags;

  tval_t             last_activity_time_next;
  tval_t             press_start_time_next;
  logic              was_pressed_next;
  bpdc_pkg::flags_t  flags_next;

  bpdc_pkg::reg_idx_t reg_sel;
  logic              cfg_wr;
  logic              poll_acc;
  logic              res_valid;
  logic              res_taken;
  bpdc_pkg::flags_t  res_flags;

  tval_t             now_t;
  tval_t             since_act;
  tval_t             held;
  logic              down;
  logic              taken;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = bpdc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms    <= bpdc_pkg::DEBOUNCE_RST;
      select_hold_ms <= bpdc_pkg::SELECT_HOLD_RST;
      escape_hold_ms <= bpdc_pkg::ESCAPE_HOLD_RST;
      active_level   <= bpdc_pkg::ACTIVE_LEVEL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        bpdc_pkg::REG_DEBOUNCE:     debounce_ms    <= pwdata[bpdc_pkg::HOLD_W-1:0];
        bpdc_pkg::REG_SELECT_HOLD:  select_hold_ms <= pwdata[bpdc_pkg::HOLD_W-1:0];
        bpdc_pkg::REG_ESCAPE_HOLD:  escape_hold_ms <= pwdata[bpdc_pkg::HOLD_W-1:0];
        bpdc_pkg::REG_ACTIVE_LEVEL: active_level   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bpdc_pkg::REG_DEBOUNCE:     prdata = bpdc_pkg::APB_DW'(debounce_ms);
      bpdc_pkg::REG_SELECT_HOLD:  prdata = bpdc_pkg::APB_DW'(select_hold_ms);
      bpdc_pkg::REG_ESCAPE_HOLD:  prdata = bpdc_pkg::APB_DW'(escape_hold_ms);
      bpdc_pkg::REG_ACTIVE_LEVEL: prdata = bpdc_pkg::APB_DW'(active_level);
      default:                    prdata = '0;
    endcase
  end

  // handshake: result register drains while a new poll comes in
  assign poll.ready = !res_valid || result.ready;
  assign poll_acc   = poll.valid && poll.ready;

  // classification
  assign now_t     = tval_t'(poll.now_ms);
  assign down      = (poll.button_level == active_level);
  assign since_act = now_t - last_activity_time;
  assign taken     = !((since_act < tval_t'(debounce_ms)) && !flags.long_press);

  always_comb begin
    last_activity_time_next = last_activity_time;
    press_start_time_next   = press_start_time;
    was_pressed_next        = was_pressed;
    flags_next              = flags;
    held                    = now_t - press_start_time;
    if (taken) begin
      flags_next.next_press   = 1'b0;
      flags_next.select_press = 1'b0;
      flags_next.escape_press = 1'b0;
      flags_next.any_key      = 1'b0;
      if (down && !was_pressed) begin
        was_pressed_next      = 1'b1;
        press_start_time_next = now_t;
        flags_next.long_press = 1'b0;
        held                  = '0;
      end
      if (down) begin
        last_activity_time_next = now_t;
        flags_next.any_key      = 1'b1;
        if (held >= tval_t'(select_hold_ms)) begin
          flags_next.long_press = 1'b1;
        end
      end else if (was_pressed) begin
        was_pressed_next = 1'b0;
        priority if (held >= tval_t'(escape_hold_ms)) begin
          flags_next.escape_press = 1'b1;
        end else if (held >= tval_t'(select_hold_ms)) begin
          flags_next.select_press = 1'b1;
        end else begin
          flags_next.next_press = 1'b1;
        end
        flags_next.any_key    = 1'b1;
        flags_next.long_press = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_activity_time <= '0;
      press_start_time   <= '0;
      was_pressed        <= 1'b0;
      flags              <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (poll_acc) begin
        last_activity_time <= last_activity_time_next;
        press_start_time   <= press_start_time_next;
        was_pressed        <= was_pressed_next;
        flags              <= flags_next;
        res_valid          <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_acc) begin
      res_taken <= taken;
      res_flags <= flags_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.poll_taken   = res_taken;
  assign result.next_press   = res_flags.next_press;
  assign result.select_press = res_flags.select_press;
  assign result.escape_press = res_flags.escape_press;
  assign result.any_key      = res_flags.any_key;
  assign result.long_press   = res_flags.long_press;

`ifndef SYNTHESIS
  a_one_release: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0({res_flags.next_press, res_flags.select_press,
                            res_flags.escape_press}))
    else $error("more than one release class");

  a_release_flags: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_flags.next_press || res_flags.select_press ||
                   res_flags.escape_press))
      |-> (res_flags.any_key && !res_flags.long_press))
    else $error("release without any_key or with long_press");

  a_long_held: assert property (@(posedge clk) disable iff (rst)
    flags.long_press |-> (was_pressed && flags.any_key))
    else $error("long_press while not held");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    poll_acc |=> (res_valid && res_flags == $past(flags_next)))
    else $error("accepted poll not reflected in result");
`endif

endmodule
